FILE: src/mwo_pkg.sv
// Shared types, constants and sine table builder for the multi-waveform oscillator.
`default_nettype none
package mwo_pkg;

	// Parameter defaults
	localparam int PHASE_WIDTH_DEF      = 32;
	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int SAMPLE_WIDTH_DEF     = 16;

	// Fixed field widths
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int STEP_W      = 32;
	localparam int AMP_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int OUT_W       = 16;
	localparam int ROM_DATA_W  = 15;

	// Waveform values are Q1.15 with |w| <= 1.0, so one extra bit over 16
	localparam int WAVE_W = 17;
	localparam logic signed [WAVE_W-1:0] WAVE_FULL_POS = 17'sd32768;
	localparam logic signed [WAVE_W-1:0] WAVE_FULL_NEG = -17'sd32768;
	localparam logic signed [WAVE_W-1:0] WAVE_ZERO     = 17'sd0;

	// Triangle ramp offsets, one bit wider than the waveform to hold the rising and falling forms
	localparam logic signed [WAVE_W:0] TRI_UP_OFS   = 18'sd32768;
	localparam logic signed [WAVE_W:0] TRI_DOWN_OFS = 18'sd98304;

	// Product of |w| and amplitude, rounding point of the Q30 scale
	localparam int PROD_W    = 32;
	localparam int ROUND_SH  = 30;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAVE_SELECT  = 2'd0,
		REG_PHASE_STEP   = 2'd1,
		REG_AMPLITUDE    = 2'd2,
		REG_SQUARE_HIGH  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_TRIANGLE = 2'd2
	} wave_t;

	// Register reset values
	localparam logic [1:0]        WAVE_SELECT_RST = 2'd0;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST  = 32'd39370534;
	localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 16'd16384;
	localparam logic [FRAC_W-1:0] SQUARE_HIGH_RST = 16'd32768;

	// Address bits of the quarter-wave table: floor(log2(depth)), at most 12
	function automatic int rom_bits(input int depth);
		int b;
		b = 0;
		while (b < 12 && (2 << b) <= depth) begin
			b = b + 1;
		end
		return b;
	endfunction

	// sin(pi/2 * u), u in Q30, result Q15 rounded and capped; odd Taylor series to degree 11
	function automatic logic [ROM_DATA_W-1:0] quarter_sine(input logic [63:0] u);
		logic [63:0] coef [6];
		logic [63:0] u2;
		logic [63:0] pw;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		logic [63:0] s;
		coef[0] = 64'd1686629713;
		coef[1] = 64'd693598668;
		coef[2] = 64'd85569306;
		coef[3] = 64'd5026995;
		coef[4] = 64'd172272;
		coef[5] = 64'd3864;
		u2  = (u * u) >> 30;
		pw  = u;
		pos = 64'd0;
		neg = 64'd0;
		for (int k = 0; k < 6; k++) begin
			term = (coef[k] * pw) >> 30;
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
			pw = (pw * u2) >> 30;
		end
		s = (pos > neg) ? pos - neg : 64'd0;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[ROM_DATA_W-1:0];
	endfunction

	// Table entry i samples the quarter wave at the middle of its step
	function automatic logic [ROM_DATA_W-1:0] sine_entry(input int i, input int bits);
		logic [63:0] u;
		u = ((64'(2 * i + 1)) << 29) >> bits;
		return quarter_sine(u);
	endfunction

endpackage
`default_nettype wire

FILE: src/mwo_wave.sv
// Waveform stage: phase fraction to a Q1.15 sine, square or triangle value.
`default_nettype none
module mwo_wave #(
	parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              advance,
	input  wire logic [mwo_pkg::FRAC_W-1:0]        frac_s1,
	input  wire mwo_pkg::wave_t                    wave_select,
	input  wire logic [mwo_pkg::FRAC_W-1:0]        square_high_fraction,
	output logic signed [mwo_pkg::WAVE_W-1:0]      wave_s2
);

	localparam int ROM_BITS = mwo_pkg::rom_bits(SINE_TABLE_DEPTH);
	localparam int ROM_N    = 1 << ROM_BITS;

	logic [mwo_pkg::ROM_DATA_W-1:0] sine_rom [ROM_N];

	for (genvar g = 0; g < ROM_N; g++) begin : g_rom
		assign sine_rom[g] = mwo_pkg::sine_entry(g, ROM_BITS);
	end

	logic [ROM_BITS-1:0]                 rom_idx;
	logic [mwo_pkg::ROM_DATA_W-1:0]      rom_val;
	logic signed [mwo_pkg::WAVE_W-1:0]   sine_w;
	logic signed [mwo_pkg::WAVE_W-1:0]   square_w;
	logic signed [mwo_pkg::WAVE_W:0]     tri_wide;
	logic signed [mwo_pkg::WAVE_W-1:0]   wave_d;

	always_comb begin
		// Quadrant in the top two bits; mirror the index on odd quadrants
		rom_idx = frac_s1[mwo_pkg::FRAC_W-3 -: ROM_BITS];
		if (frac_s1[mwo_pkg::FRAC_W-2]) begin
			rom_idx = ~rom_idx;
		end
		rom_val = sine_rom[rom_idx];
		sine_w  = $signed({2'b00, rom_val});
		if (frac_s1[mwo_pkg::FRAC_W-1]) begin
			sine_w = -sine_w;
		end

		square_w = (frac_s1 < square_high_fraction) ? mwo_pkg::WAVE_FULL_POS
		                                            : mwo_pkg::WAVE_FULL_NEG;

		if (!frac_s1[mwo_pkg::FRAC_W-1]) begin
			tri_wide = $signed({1'b0, frac_s1, 1'b0}) - mwo_pkg::TRI_UP_OFS;
		end else begin
			tri_wide = mwo_pkg::TRI_DOWN_OFS - $signed({1'b0, frac_s1, 1'b0});
		end

		case (wave_select)
			mwo_pkg::WAVE_SINE:     wave_d = sine_w;
			mwo_pkg::WAVE_SQUARE:   wave_d = square_w;
			mwo_pkg::WAVE_TRIANGLE: wave_d = tri_wide[mwo_pkg::WAVE_W-1:0];
			default:                wave_d = mwo_pkg::WAVE_ZERO;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wave_s2 <= wave_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/mwo_scale.sv
// Gain stage: amplitude multiply, rounding and saturation to the sample width.
`default_nettype none
module mwo_scale #(
	parameter int SAMPLE_WIDTH = mwo_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              advance,
	input  wire logic signed [mwo_pkg::WAVE_W-1:0] wave_s2,
	input  wire logic [mwo_pkg::AMP_W-1:0]         amplitude,
	output logic [mwo_pkg::OUT_W-1:0]              sample_q
);

	localparam int SCALED_W = mwo_pkg::PROD_W + SAMPLE_WIDTH - 1;
	localparam int MAG_W    = SAMPLE_WIDTH + 1;
	localparam logic [MAG_W-1:0] MAX_POS = MAG_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic [MAG_W-1:0] MAX_NEG = MAG_W'(1 << (SAMPLE_WIDTH - 1));
	localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1 << (mwo_pkg::ROUND_SH - 1));

	logic [mwo_pkg::WAVE_W-1:0]         wave_neg;
	logic [mwo_pkg::AMP_W-1:0]          wave_mag;
	logic [mwo_pkg::PROD_W-1:0]         prod_s3;
	logic                               neg_s3;
	logic [SCALED_W-1:0]                scaled;
	logic [MAG_W-1:0]                   mag;
	logic [MAG_W-1:0]                   mag_sat;
	logic [MAG_W-1:0]                   signed_mag;
	logic signed [SAMPLE_WIDTH-1:0]     value;
	logic signed [31:0]                 value_ext;

	always_comb begin
		wave_neg = mwo_pkg::WAVE_W'(-wave_s2);
		wave_mag = wave_s2[mwo_pkg::WAVE_W-1] ? wave_neg[mwo_pkg::AMP_W-1:0]
		                                     : wave_s2[mwo_pkg::AMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= mwo_pkg::PROD_W'(wave_mag * amplitude);
			neg_s3  <= wave_s2[mwo_pkg::WAVE_W-1];
		end
	end

	always_comb begin
		// Round half away from zero on the magnitude, then apply the sign
		scaled = {prod_s3, {(SAMPLE_WIDTH - 1){1'b0}}} + ROUND_HALF;
		mag    = scaled[SCALED_W-1 -: MAG_W];
		if (neg_s3) begin
			mag_sat    = (mag > MAX_NEG) ? MAX_NEG : mag;
			signed_mag = MAG_W'(-mag_sat);
		end else begin
			mag_sat    = (mag > MAX_POS) ? MAX_POS : mag;
			signed_mag = mag_sat;
		end
		value     = $signed(signed_mag[SAMPLE_WIDTH-1:0]);
		value_ext = 32'(value);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= value_ext[mwo_pkg::OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: src/multi_waveform_oscillator.sv
// Top level of the multi-waveform direct digital synthesis oscillator.
`default_nettype none
// Each request is one sample tick: the phase accumulator (restart clears it first) selects a
// sine from a quarter-wave table, a square with programmable high fraction, or a symmetric
// triangle, scaled by a Q1.15 amplitude and saturated to SAMPLE_WIDTH bits, then returned as a
// 16-bit two's complement sample. One request is taken every clock while in_stall is low; the
// result passes through the phase, waveform, multiply and output registers in turn. A stall on
// the output holds the whole pipeline and shows on in_stall in the same cycle. Write the
// configuration registers only while no request is in flight.
module multi_waveform_oscillator #(
	parameter int PHASE_WIDTH      = mwo_pkg::PHASE_WIDTH_DEF,
	parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int SAMPLE_WIDTH     = mwo_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write_en,
	input  wire logic [mwo_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mwo_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               restart,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [mwo_pkg::OUT_W-1:0]               sample
);

	mwo_pkg::wave_t                     wave_select_q;
	logic [mwo_pkg::STEP_W-1:0]         phase_step_q;
	logic [mwo_pkg::AMP_W-1:0]          amplitude_q;
	logic [mwo_pkg::FRAC_W-1:0]         square_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q <= mwo_pkg::wave_t'(mwo_pkg::WAVE_SELECT_RST);
			phase_step_q  <= mwo_pkg::PHASE_STEP_RST;
			amplitude_q   <= mwo_pkg::AMPLITUDE_RST;
			square_high_q <= mwo_pkg::SQUARE_HIGH_RST;
		end else if (cfg_write_en) begin
			case (mwo_pkg::cfg_reg_t'(cfg_index))
				mwo_pkg::REG_WAVE_SELECT: wave_select_q <= mwo_pkg::wave_t'(cfg_data[1:0]);
				mwo_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data[mwo_pkg::STEP_W-1:0];
				mwo_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data[mwo_pkg::AMP_W-1:0];
				mwo_pkg::REG_SQUARE_HIGH: square_high_q <= cfg_data[mwo_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	logic                       advance;
	logic                       accept;
	logic [PHASE_WIDTH-1:0]     phase_q;
	logic [PHASE_WIDTH-1:0]     phase_cur;
	logic [mwo_pkg::FRAC_W-1:0] frac_s1;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       valid_s3;
	logic                       out_valid_q;

	// Hold every stage while a finished sample waits on the output
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign phase_cur = restart ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (accept) begin
				phase_q <= phase_cur + PHASE_WIDTH'(phase_step_q);
			end
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frac_s1 <= phase_cur[PHASE_WIDTH-1 -: mwo_pkg::FRAC_W];
		end
	end

	logic signed [mwo_pkg::WAVE_W-1:0] wave_s2;

	mwo_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_wave (
		.clk                  (clk),
		.advance              (advance),
		.frac_s1              (frac_s1),
		.wave_select          (wave_select_q),
		.square_high_fraction (square_high_q),
		.wave_s2              (wave_s2)
	);

	mwo_scale #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_scale (
		.clk       (clk),
		.advance   (advance),
		.wave_s2   (wave_s2),
		.amplitude (amplitude_q),
		.sample_q  (sample)
	);

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: verif/mwo_sample_checker.sv
// Sample predictor and result checker for the multi-waveform oscillator.
module mwo_sample_checker
	import mwo_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic                   restart,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [OUT_W-1:0]       sample,
	output int                          failures,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Depth is a power of two here, so its log2 is exact
	localparam int TABLE_BITS = $clog2(SINE_TABLE_DEPTH_DEF);
	localparam int TABLE_SIZE = 1 << TABLE_BITS;

	logic [14:0] quarter_wave [TABLE_SIZE];

	logic [31:0] phase;
	logic [1:0]  wave_sel;
	logic [31:0] step;
	logic [15:0] gain;
	logic [15:0] high_frac;

	logic [15:0] pending_samples [$];

	// sin(pi/2 * u) with u in Q30, Q15 result, odd series up to the 11th power
	function automatic logic [14:0] sine_q15(input logic [63:0] u);
		logic [63:0] taylor [6];
		logic [63:0] u_sq;
		logic [63:0] power;
		logic [63:0] plus;
		logic [63:0] minus;
		logic [63:0] term;
		logic [63:0] s;
		taylor = '{64'd1686629713, 64'd693598668, 64'd85569306,
			64'd5026995, 64'd172272, 64'd3864};
		u_sq = (u * u) >> 30;
		power = u;
		plus = 64'd0;
		minus = 64'd0;
		for (int k = 0; k < 6; k++) begin
			term = (taylor[k] * power) >> 30;
			if (k % 2 == 1) begin
				minus += term;
			end else begin
				plus += term;
			end
			power = (power * u_sq) >> 30;
		end
		s = (plus > minus) ? plus - minus : 64'd0;
		s = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[14:0];
	endfunction

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			quarter_wave[i] = sine_q15((64'(2 * i + 1) << 29) >> TABLE_BITS);
		end
	end

	// Apply the Q1.15 gain with round half away from zero, then saturate
	function automatic logic [15:0] scaled_sample(input int w);
		logic [63:0] mag;
		logic [63:0] v;
		mag = (w < 0) ? 64'(-w) : 64'(w);
		mag = (mag * gain * 64'd32768 + (64'd1 << 29)) >> 30;
		if (w >= 0) begin
			v = (mag > 64'd32767) ? 64'd32767 : mag;
		end else begin
			if (mag > 64'd32768) begin
				mag = 64'd32768;
			end
			v = 64'd0 - mag;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] predict_sample(input logic [31:0] ph);
		logic [TABLE_BITS-1:0] idx;
		int                    frac;
		int                    w;
		frac = int'(ph[31:16]);
		case (wave_sel)
			WAVE_SINE: begin
				idx = ph[29 -: TABLE_BITS];
				// mirror the table on the falling quarters, negate the lower half
				if (ph[30]) begin
					idx = ~idx;
				end
				w = int'(quarter_wave[idx]);
				if (ph[31]) begin
					w = -w;
				end
				return scaled_sample(w);
			end
			WAVE_SQUARE: begin
				w = (frac < int'(high_frac)) ? 32768 : -32768;
				return scaled_sample(w);
			end
			WAVE_TRIANGLE: begin
				w = (frac < 32768) ? 2 * frac - 32768 : 98304 - 2 * frac;
				return scaled_sample(w);
			end
			default: return 16'd0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] tick_phase;
		logic [15:0] want;
		if (!arst_n) begin
			phase <= 32'd0;
			wave_sel <= 2'd0;
			step <= 32'd39370534;
			gain <= 16'd16384;
			high_frac <= 16'd32768;
			pending_samples.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_WAVE_SELECT: wave_sel <= cfg_data[1:0];
					REG_PHASE_STEP:  step <= cfg_data;
					REG_AMPLITUDE:   gain <= cfg_data[15:0];
					REG_SQUARE_HIGH: high_frac <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				tick_phase = restart ? 32'd0 : phase;
				pending_samples.push_back(predict_sample(tick_phase));
				phase <= tick_phase + step;
			end
			if (out_valid && !out_stall) begin
				if (pending_samples.size() == 0) begin
					$error("sample arrived with none expected: got %0d", $signed(sample));
					failures++;
				end else begin
					want = pending_samples.pop_front();
					if (want !== sample) begin
						$error("sample mismatch: expected %0d, got %0d",
							$signed(want), $signed(sample));
						failures++;
					end
				end
			end
			outstanding <= pending_samples.size();
		end
	end

endmodule

FILE: verif/multi_waveform_oscillator_test.sv
// Stimulus and verdict for the multi-waveform oscillator.
module multi_waveform_oscillator_test;
	import mwo_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] WAVE_UNUSED = 2'd3;
	localparam int         HOLD_CYCLES = 60;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   restart;
	logic                   out_valid;
	logic                   out_stall;
	logic [OUT_W-1:0]       sample;

	int   failures;
	int   outstanding;
	logic calm = 1'b0;
	int   hold_requests = 0;

	int ticks_sent = 0;
	int restarts_sent = 0;
	int settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_waveform_oscillator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample)
	);

	mwo_sample_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	// Output side: random stalls, quiet while calm, and long hold-offs on request
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 26);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout: oscillator run did not complete");
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_tick(input logic rs);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
		if (rs) begin
			restarts_sent++;
		end
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Drain the pipeline, write the chosen registers, then send a burst of ticks,
	// holding off the output for a long stretch while the burst runs when asked
	task automatic run_phase(input logic [3:0] which, input logic [1:0] wave,
			input logic [31:0] step, input logic [15:0] amp, input logic [15:0] high,
			input int count, input bit directed, input bit hold);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (which[0]) put_reg(REG_WAVE_SELECT, {30'd0, wave});
		if (which[1]) put_reg(REG_PHASE_STEP, step);
		if (which[2]) put_reg(REG_AMPLITUDE, {16'd0, amp});
		if (which[3]) put_reg(REG_SQUARE_HIGH, {16'd0, high});
		cfg_write_en <= 1'b0;
		settings_used++;
		if (hold) begin
			hold_requests <= hold_requests + 1;
		end
		for (int n = 0; n < count; n++) begin
			if (directed) begin
				send_tick(n == 0);
			end else begin
				send_tick($urandom_range(99) < 4);
			end
		end
	endtask

	initial begin
		int          random_ticks;
		int          phase_no;
		int          pick;
		logic [3:0]  which;
		logic [1:0]  wave;
		logic [31:0] step;
		logic [15:0] amp;
		logic [15:0] high;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings first, then the corners of every waveform
		run_phase(4'b0000, WAVE_SINE, 32'd0, 16'd0, 16'd0, 3, 1'b1, 1'b0);
		run_phase(4'b1111, WAVE_TRIANGLE, 32'h4000_0000, 16'd32768, 16'd32768, 5, 1'b1, 1'b0);
		run_phase(4'b1111, WAVE_SQUARE, 32'h8000_0000, 16'hFFFF, 16'd0, 3, 1'b1, 1'b0);
		run_phase(4'b1111, WAVE_SQUARE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3, 1'b1, 1'b0);
		run_phase(4'b0111, WAVE_SINE, 32'h0040_0000, 16'd0, 16'd0, 3, 1'b1, 1'b0);
		run_phase(4'b0111, WAVE_UNUSED, 32'h0000_0001, 16'd32768, 16'd0, 3, 1'b1, 1'b0);
		run_phase(4'b0111, WAVE_SINE, 32'h3FC0_0000, 16'd32768, 16'd0, 3, 1'b1, 1'b0);

		random_ticks = 0;
		phase_no = 0;
		while (random_ticks < 1530) begin
			pick = $urandom_range(15);
			wave = (pick < 5) ? WAVE_SINE : (pick < 10) ? WAVE_SQUARE :
				(pick < 15) ? WAVE_TRIANGLE : WAVE_UNUSED;
			case ($urandom_range(4))
				0: step = $urandom();
				1: step = $urandom_range(1, 1 << 20);
				2: step = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
				3: step = {8'($urandom_range(255)), 24'd0};
				default: step = ($urandom_range(1)) ? 32'd0 : 32'hFFFF_FFFF;
			endcase
			case ($urandom_range(3))
				0: amp = 16'd32768;
				1: amp = 16'($urandom_range(0, 32768));
				2: amp = 16'($urandom_range(32769, 65535));
				default: amp = ($urandom_range(1)) ? 16'd0 : 16'hFFFF;
			endcase
			case ($urandom_range(3))
				0: high = 16'($urandom_range(0, 65535));
				1: high = 16'd0;
				2: high = 16'hFFFF;
				default: high = 16'd32768;
			endcase
			for (int r = 0; r < 4; r++) begin
				which[r] = ($urandom_range(3) != 0);
			end
			calm <= (random_ticks >= 600 && random_ticks < 800);
			pick = $urandom_range(20, 110);
			run_phase(which, wave, step, amp, high, pick, 1'b0,
				(phase_no == 3 || phase_no == 12));
			random_ticks += pick;
			phase_no++;
		end

		in_valid <= 1'b0;
		calm <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d sample ticks (%0d with restart) over %0d oscillator settings,",
			ticks_sent, restarts_sent, settings_used);
		$display("all wave selects, gain and duty corners, and %0d long output hold-offs.",
			hold_requests);
		if (failures == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/mwo_pkg.sv
src/mwo_wave.sv
src/mwo_scale.sv
src/multi_waveform_oscillator.sv
verif/mwo_sample_checker.sv
verif/multi_waveform_oscillator_test.sv
